[sv/psc_pkg.sv]
// Shared types, widths and register indexes for the particle sphere collision block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package psc_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int GAIN_BITS = 18;
	localparam int GAIN_FRAC = 16;
	localparam int MAG_BITS  = WORD_BITS - 1;             // |centre - position| when near
	localparam int SQ_BITS   = 2 * WORD_BITS;             // squared distance, Q32.32
	localparam int ROOT_BITS = MAG_BITS;                  // floor(sqrt), Q16.16
	localparam int NUM_BITS  = MAG_BITS + FRAC_BITS + 1;  // divider dividend
	localparam int QUO_BITS  = FRAC_BITS + 1;             // |n| <= 1.0
	localparam int IDX_BITS  = 3;

	localparam logic [IDX_BITS-1:0] REG_MODE     = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_GAIN     = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_CENTER_X = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_CENTER_Y = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_CENTER_Z = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_RADIUS   = 3'd5;

	localparam logic [GAIN_BITS-1:0] GAIN_RST   = GAIN_BITS'(1) << (GAIN_FRAC - 1);
	localparam logic [MAG_BITS-1:0]  RADIUS_RST = MAG_BITS'(1) << FRAC_BITS;

	typedef logic signed [WORD_BITS-1:0] word_t;

	// Sideband carried alongside the square root and divider pipelines
	typedef struct packed {
		word_t [2:0]                  pos;
		word_t [2:0]                  vel;
		logic  [2:0][MAG_BITS-1:0]    mag;
		logic  [2:0]                  neg;
		logic                         hit;
		logic                         bounce;
	} psc_side_t;

	typedef struct packed {
		word_t [2:0] pos;
		word_t [2:0] vel;
		logic        hit;
		logic        killed;
	} psc_res_t;

	function automatic word_t sat_word(input logic signed [SQ_BITS-1:0] x);
		logic signed [SQ_BITS-1:0] hi;
		logic signed [SQ_BITS-1:0] lo;
		hi = SQ_BITS'((SQ_BITS'(1) << (WORD_BITS - 1)) - SQ_BITS'(1));
		lo = -hi - SQ_BITS'(1);
		if (x > hi)
			return hi[WORD_BITS-1:0];
		else if (x < lo)
			return lo[WORD_BITS-1:0];
		else
			return x[WORD_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

[sv/psc_if.sv]
// Channel interfaces: particle input, result output and configuration write.
// Depends on psc_pkg.
`default_nettype none

interface psc_in_if;
	logic                valid;
	logic                ready;
	psc_pkg::word_t      pos_x;
	psc_pkg::word_t      pos_y;
	psc_pkg::word_t      pos_z;
	psc_pkg::word_t      vel_x;
	psc_pkg::word_t      vel_y;
	psc_pkg::word_t      vel_z;

	modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
	modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

interface psc_out_if;
	logic                valid;
	logic                ready;
	psc_pkg::word_t      new_pos_x;
	psc_pkg::word_t      new_pos_y;
	psc_pkg::word_t      new_pos_z;
	psc_pkg::word_t      new_vel_x;
	psc_pkg::word_t      new_vel_y;
	psc_pkg::word_t      new_vel_z;
	logic                inside_hit;
	logic                killed;

	modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
		new_vel_z, inside_hit, killed, input ready);
	modport sink   (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
		new_vel_z, inside_hit, killed, output ready);
endinterface

interface psc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [psc_pkg::IDX_BITS-1:0]     index;
	logic [psc_pkg::WORD_BITS-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/psc_sqrt.sv]
// Pipelined integer square root, one result bit per stage, sideband carried along.
// Depends on psc_pkg.
`default_nettype none

module psc_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [psc_pkg::SQ_BITS-1:0]       in_sq,
	input  psc_pkg::psc_side_t                in_side,
	output logic                              out_valid,
	output logic [psc_pkg::ROOT_BITS-1:0]     out_root,
	output psc_pkg::psc_side_t                out_side
);

	localparam int NS = psc_pkg::ROOT_BITS;
	localparam int SQ = psc_pkg::SQ_BITS;

	logic                vld_s  [NS];
	logic [SQ-1:0]       rem_s  [NS];
	logic [NS-1:0]       root_s [NS];
	psc_pkg::psc_side_t  side_s [NS];

	for (genvar j = 0; j < NS; j++) begin : g_stage
		localparam int K = NS - 1 - j;
		logic                vld_in;
		logic [SQ-1:0]       rem_in;
		logic [NS-1:0]       root_in;
		psc_pkg::psc_side_t  side_in;
		logic [SQ-1:0]       trial;
		logic                take;

		if (j == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = in_sq;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign root_in = root_s[j-1];
			assign side_in = side_s[j-1];
		end

		// (root + 2^K)^2 - root^2, root holding only the bits above K
		assign trial = ({{(SQ-NS){1'b0}}, root_in} << (K + 1))
			+ ({{(SQ-1){1'b0}}, 1'b1} << (2 * K));
		assign take  = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[j] <= 1'b0;
			else if (en)
				vld_s[j] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= take ? rem_in - trial : rem_in;
				root_s[j] <= take ? (root_in | ({{(NS-1){1'b0}}, 1'b1} << K)) : root_in;
				side_s[j] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_root  = root_s[NS-1];
	assign out_side  = side_s[NS-1];

endmodule

`default_nettype wire

[sv/psc_div.sv]
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit a stage.
// Forms the rounded unit normal magnitudes; depends on psc_pkg.
`default_nettype none

module psc_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic [psc_pkg::ROOT_BITS-1:0]          in_len,
	input  psc_pkg::psc_side_t                     in_side,
	output logic                                   out_valid,
	output logic [2:0][psc_pkg::QUO_BITS-1:0]      out_quo,
	output logic [psc_pkg::ROOT_BITS-1:0]          out_len,
	output psc_pkg::psc_side_t                     out_side
);

	localparam int NS = psc_pkg::QUO_BITS;
	localparam int NB = psc_pkg::NUM_BITS;
	localparam int RB = psc_pkg::ROOT_BITS;
	localparam int FB = psc_pkg::FRAC_BITS;

	logic                       vld_s  [NS];
	logic [2:0][NB-1:0]         rem_s  [NS];
	logic [2:0][NS-1:0]         quo_s  [NS];
	logic [RB-1:0]              len_s  [NS];
	psc_pkg::psc_side_t         side_s [NS];

	// (mag << FRAC) + len/2 : quotient is round-to-nearest of mag / len
	logic [2:0][NB-1:0] num0;
	always_comb begin
		for (int l = 0; l < 3; l++)
			num0[l] = {1'b0, in_side.mag[l], {FB{1'b0}}}
				+ {{(NB-RB+1){1'b0}}, in_len[RB-1:1]};
	end

	for (genvar j = 0; j < NS; j++) begin : g_stage
		localparam int K = NS - 1 - j;
		logic                       vld_in;
		logic [2:0][NB-1:0]         rem_in;
		logic [2:0][NS-1:0]         quo_in;
		logic [RB-1:0]              len_in;
		psc_pkg::psc_side_t         side_in;
		logic [NB-1:0]              dsh;
		logic [2:0][NB-1:0]         rem_nx;
		logic [2:0][NS-1:0]         quo_nx;

		if (j == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = num0;
			assign quo_in  = '0;
			assign len_in  = in_len;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign quo_in  = quo_s[j-1];
			assign len_in  = len_s[j-1];
			assign side_in = side_s[j-1];
		end

		assign dsh = {{(NB-RB){1'b0}}, len_in} << K;

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				if (rem_in[l] >= dsh) begin
					rem_nx[l] = rem_in[l] - dsh;
					quo_nx[l] = quo_in[l] | ({{(NS-1){1'b0}}, 1'b1} << K);
				end else begin
					rem_nx[l] = rem_in[l];
					quo_nx[l] = quo_in[l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[j] <= 1'b0;
			else if (en)
				vld_s[j] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= rem_nx;
				quo_s[j]  <= quo_nx;
				len_s[j]  <= len_in;
				side_s[j] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_quo   = quo_s[NS-1];
	assign out_len   = len_s[NS-1];
	assign out_side  = side_s[NS-1];

endmodule

`default_nettype wire

[sv/psc_skid.sv]
// Two-entry output buffer between the pipeline and the result channel.
// Depends on psc_pkg.
`default_nettype none

module psc_skid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  psc_pkg::psc_res_t   din,
	output logic                full,
	input  logic                pop_ready,
	output logic                out_valid,
	output psc_pkg::psc_res_t   dout
);

	logic [1:0]          cnt_q;
	psc_pkg::psc_res_t   head_q;
	psc_pkg::psc_res_t   tail_q;
	logic                pop;

	assign out_valid = cnt_q != 2'd0;
	assign full      = cnt_q == 2'd2;
	assign pop       = out_valid && pop_ready;
	assign dout      = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0)
					head_q <= din;
				else
					tail_q <= din;
			end
			2'b01: head_q <= tail_q;
			2'b11: head_q <= din;   // only with one entry held
			default: head_q <= head_q;
		endcase
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("skid count out of range");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("push into full skid buffer");
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !pop_ready) |=> full)
		else $error("full skid buffer lost an entry without a pop");
`endif

endmodule

`default_nettype wire

[sv/particle_sphere_collision.sv]
// Particle sphere collision: front end, square root, divider and bounce arithmetic stages.
// Depends on psc_pkg, psc_if, psc_sqrt, psc_div and psc_skid.
//
// Usage:
//   cfg      : register writes (index 0 mode, 1 gain, 2..4 centre x/y/z, 5 radius);
//              always ready, indexes beyond the list are ignored. Write only while idle.
//   particle : one position/velocity transaction per cycle when ready is high.
//   result   : one transaction per particle, in order, with new position and velocity,
//              inside_hit and killed.
// Result valid rises once an accepted particle has passed through 4 front-end stages
// (distance, squares, sum, inside test), 31 square-root stages, 17 divider stages,
// 5 bounce stages, then the output buffer register. One particle per cycle unless frozen.
// The whole pipeline advances together; it freezes only while the two-entry output
// buffer is full, so particle.ready drops once two results wait in the buffer and
// nothing is lost or repeated. particle.ready does not depend on result.ready.
// Reset empties the pipeline and buffer and loads the register defaults: kill mode,
// gain 0.5, centre at the origin, radius 1.0.
`default_nettype none

module particle_sphere_collision (
	input  logic              clk,
	input  logic              arst_n,
	psc_cfg_if.sink           cfg,
	psc_in_if.sink            particle,
	psc_out_if.source         result
);

	localparam int W   = psc_pkg::WORD_BITS;
	localparam int FB  = psc_pkg::FRAC_BITS;
	localparam int MB  = psc_pkg::MAG_BITS;
	localparam int SQ  = psc_pkg::SQ_BITS;
	localparam int RB  = psc_pkg::ROOT_BITS;
	localparam int QB  = psc_pkg::QUO_BITS;
	localparam int GB  = psc_pkg::GAIN_BITS;
	localparam int GF  = psc_pkg::GAIN_FRAC;
	localparam int NB  = QB + 1;          // signed normal component
	localparam int PB  = NB + W;          // n * shift, v * n
	localparam int DB  = PB + 2;          // dot product sum
	localparam int VB  = DB - FB;         // vn
	localparam int GPB = VB + GB + 1;     // vn * gain
	localparam int KB  = GPB + 1 - GF;    // k
	localparam int KNB = KB + NB;         // k * n

	localparam logic [PB-1:0]  HALF_P  = PB'(1) << (FB - 1);
	localparam logic [DB-1:0]  HALF_D  = DB'(1) << (FB - 1);
	localparam logic [GPB:0]   HALF_G  = (GPB + 1)'(1) << (GF - 1);
	localparam logic [KNB-1:0] HALF_KN = KNB'(1) << (FB - 1);

	// ---------------- configuration ----------------
	logic                mode_q;
	logic [GB-1:0]       gain_q;
	psc_pkg::word_t      cen_q [3];
	logic [MB-1:0]       radius_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			gain_q   <= psc_pkg::GAIN_RST;
			cen_q[0] <= '0;
			cen_q[1] <= '0;
			cen_q[2] <= '0;
			radius_q <= psc_pkg::RADIUS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				psc_pkg::REG_MODE:     mode_q   <= cfg.data[0];
				psc_pkg::REG_GAIN:     gain_q   <= cfg.data[GB-1:0];
				psc_pkg::REG_CENTER_X: cen_q[0] <= cfg.data;
				psc_pkg::REG_CENTER_Y: cen_q[1] <= cfg.data;
				psc_pkg::REG_CENTER_Z: cen_q[2] <= cfg.data;
				psc_pkg::REG_RADIUS:   radius_q <= cfg.data[MB-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	logic en;
	logic skid_full;
	assign en             = !skid_full;
	assign particle.ready = en;

	// ---------------- S1: offset, magnitude, near test ----------------
	psc_pkg::word_t      pin [3];
	psc_pkg::word_t      vin [3];
	logic signed [W:0]   dif [3];
	logic [W:0]          absd [3];
	logic [2:0]          near_c;

	assign pin[0] = particle.pos_x;
	assign pin[1] = particle.pos_y;
	assign pin[2] = particle.pos_z;
	assign vin[0] = particle.vel_x;
	assign vin[1] = particle.vel_y;
	assign vin[2] = particle.vel_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dif[i]    = $signed({cen_q[i][W-1], cen_q[i]}) - $signed({pin[i][W-1], pin[i]});
			absd[i]   = dif[i][W] ? (~dif[i] + 1'b1) : dif[i];
			near_c[i] = absd[i] < {2'b00, radius_q};
		end
	end

	logic                v_s1, v_s2, v_s3, v_s4;
	logic                near_s1, near_s2, near_s3;
	psc_pkg::psc_side_t  side_s1, side_s2, side_s3, side_s4;
	logic [2*MB-1:0]     sq_s2 [3];
	logic [2*MB-1:0]     r2_s2, r2_s3;
	logic [SQ-1:0]       s_s3, s_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= particle.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				side_s1.pos[i] <= pin[i];
				side_s1.vel[i] <= vin[i];
				side_s1.mag[i] <= absd[i][MB-1:0];
				side_s1.neg[i] <= dif[i][W];
			end
			side_s1.hit    <= 1'b0;
			side_s1.bounce <= 1'b0;
			near_s1        <= &near_c;

			// S2: squares
			for (int i = 0; i < 3; i++)
				sq_s2[i] <= side_s1.mag[i] * side_s1.mag[i];
			r2_s2   <= radius_q * radius_q;
			near_s2 <= near_s1;
			side_s2 <= side_s1;

			// S3: squared distance
			s_s3 <= {{(SQ-2*MB){1'b0}}, sq_s2[0]} + {{(SQ-2*MB){1'b0}}, sq_s2[1]}
				+ {{(SQ-2*MB){1'b0}}, sq_s2[2]};
			r2_s3   <= r2_s2;
			near_s3 <= near_s2;
			side_s3 <= side_s2;

			// S4: strictly inside; bounce needs a direction
			side_s4.pos    <= side_s3.pos;
			side_s4.vel    <= side_s3.vel;
			side_s4.mag    <= side_s3.mag;
			side_s4.neg    <= side_s3.neg;
			side_s4.hit    <= near_s3 && (s_s3 < {{(SQ-2*MB){1'b0}}, r2_s3});
			side_s4.bounce <= near_s3 && (s_s3 < {{(SQ-2*MB){1'b0}}, r2_s3})
				&& mode_q && (s_s3 != '0);
			s_s4           <= s_s3;
		end
	end

	// ---------------- square root and divider ----------------
	logic                     v_sq;
	logic [RB-1:0]            len_sq;
	psc_pkg::psc_side_t       side_sq;

	psc_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_sq     (s_s4),
		.in_side   (side_s4),
		.out_valid (v_sq),
		.out_root  (len_sq),
		.out_side  (side_sq)
	);

	logic                     v_dv;
	logic [2:0][QB-1:0]       quo_dv;
	logic [RB-1:0]            len_dv;
	psc_pkg::psc_side_t       side_dv;

	psc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_sq),
		.in_len    (len_sq),
		.in_side   (side_sq),
		.out_valid (v_dv),
		.out_quo   (quo_dv),
		.out_len   (len_dv),
		.out_side  (side_dv)
	);

	// ---------------- M1..M5: bounce arithmetic ----------------
	logic signed [NB-1:0]  n_c [3];
	logic signed [W-1:0]   shift_c;

	always_comb begin
		shift_c = $signed({1'b0, radius_q}) - $signed({1'b0, len_dv});
		for (int i = 0; i < 3; i++)
			n_c[i] = side_dv.neg[i] ? -$signed({1'b0, quo_dv[i]}) : $signed({1'b0, quo_dv[i]});
	end

	logic                  v_m1, v_m2, v_m3, v_m4, v_m5;
	psc_pkg::psc_side_t    side_m1, side_m2, side_m3, side_m4, side_m5;
	logic signed [NB-1:0]  n_m1 [3], n_m2 [3], n_m3 [3], n_m4 [3];
	logic signed [PB-1:0]  pn_m1 [3], vp_m1 [3];
	psc_pkg::word_t        np_m2 [3], np_m3 [3], np_m4 [3], np_m5 [3];
	logic signed [VB-1:0]  vn_m2;
	logic signed [GPB-1:0] g_m3;
	logic signed [KB-1:0]  k_m4;
	logic signed [KNB-1:0] kn_m5 [3];

	logic [PB-1:0]         pnr_c [3];
	logic signed [SQ-1:0]  npw_c [3];
	logic signed [DB-1:0]  dot_c;
	logic [DB-1:0]         dotr_c;
	logic [GPB:0]          kr_c;

	always_comb begin
		dot_c = '0;
		for (int i = 0; i < 3; i++) begin
			pnr_c[i] = pn_m1[i] + HALF_P;
			npw_c[i] = side_m1.pos[i] - $signed(pnr_c[i][PB-1:FB]);
			dot_c    = dot_c + vp_m1[i];
		end
		dotr_c = dot_c + HALF_D;
		kr_c   = {g_m3, 1'b0} + HALF_G;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_m3 <= 1'b0;
			v_m4 <= 1'b0;
			v_m5 <= 1'b0;
		end else if (en) begin
			v_m1 <= v_dv;
			v_m2 <= v_m1;
			v_m3 <= v_m2;
			v_m4 <= v_m3;
			v_m5 <= v_m4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// M1: n * (radius - len), v * n
			for (int i = 0; i < 3; i++) begin
				n_m1[i]  <= n_c[i];
				pn_m1[i] <= n_c[i] * shift_c;
				vp_m1[i] <= $signed(side_dv.vel[i]) * n_c[i];
			end
			side_m1 <= side_dv;

			// M2: pushed-out position, normal velocity
			for (int i = 0; i < 3; i++) begin
				np_m2[i] <= psc_pkg::sat_word(npw_c[i]);
				n_m2[i]  <= n_m1[i];
			end
			vn_m2   <= $signed(dotr_c[DB-1:FB]);
			side_m2 <= side_m1;

			// M3: vn * gain
			g_m3    <= vn_m2 * $signed({1'b0, gain_q});
			n_m3    <= n_m2;
			np_m3   <= np_m2;
			side_m3 <= side_m2;

			// M4: k = round(2 * vn * gain)
			k_m4    <= $signed(kr_c[GPB:GF]);
			n_m4    <= n_m3;
			np_m4   <= np_m3;
			side_m4 <= side_m3;

			// M5: k * n
			for (int i = 0; i < 3; i++)
				kn_m5[i] <= k_m4 * n_m4[i];
			np_m5   <= np_m4;
			side_m5 <= side_m4;
		end
	end

	// ---------------- final select into the output buffer ----------------
	logic [KNB-1:0]        knr_c [3];
	logic signed [SQ-1:0]  nvw_c [3];
	psc_pkg::psc_res_t     res_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			knr_c[i] = kn_m5[i] + HALF_KN;
			nvw_c[i] = side_m5.vel[i] - $signed(knr_c[i][KNB-1:FB]);
			if (side_m5.bounce) begin
				res_c.pos[i] = np_m5[i];
				res_c.vel[i] = psc_pkg::sat_word(nvw_c[i]);
			end else begin
				res_c.pos[i] = side_m5.pos[i];
				res_c.vel[i] = side_m5.vel[i];
			end
		end
		res_c.hit    = side_m5.hit;
		res_c.killed = side_m5.hit && !mode_q;
	end

	psc_pkg::psc_res_t res_q;

	psc_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (en && v_m5),
		.din       (res_c),
		.full      (skid_full),
		.pop_ready (result.ready),
		.out_valid (result.valid),
		.dout      (res_q)
	);

	assign result.new_pos_x  = res_q.pos[0];
	assign result.new_pos_y  = res_q.pos[1];
	assign result.new_pos_z  = res_q.pos[2];
	assign result.new_vel_x  = res_q.vel[0];
	assign result.new_vel_y  = res_q.vel[1];
	assign result.new_vel_z  = res_q.vel[2];
	assign result.inside_hit = res_q.hit;
	assign result.killed     = res_q.killed;

`ifndef ASSERT_OFF
	a_killed_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.killed) |-> result.inside_hit)
		else $error("killed result not flagged inside");
	a_bounce_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(v_m5 && side_m5.bounce) |-> side_m5.hit)
		else $error("bounce flagged for a particle outside the sphere");
	a_frozen_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full |=> ($stable(v_m5) && $stable(v_s1)))
		else $error("pipeline moved while the output buffer was full");
`endif

endmodule

`default_nettype wire
